/* rtl/baro_sensor_compensation_assert.svh */
// Assertion macros shared by the compensation RTL.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define BSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bsc_pkg.sv */
package bsc_pkg;

    // Field and register widths
    localparam int RAW_W     = 24;
    localparam int REG_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST   = 2'd2;

    // Sample kinds
    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_PRES = 1'b1;

    // Shared multiplier: signed MUL_A_W x signed MUL_B_W
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 28;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    // Accumulator is split into an unsigned low part and a signed high part
    localparam int SPLIT   = MUL_B_W - 1;
    localparam int ACC_W   = 2 * MUL_B_W - 2;
    localparam int PROD_W  = MUL_P_W + SPLIT;
    localparam int Q_FRAC  = 30;
    localparam int COEF_W  = ACC_W - Q_FRAC;
    localparam int RND_SHIFT = 20;

    // Scaling by 2048/15: divide by 15 via reciprocal, then a fraction table
    localparam int Q_W         = 20;
    localparam int RECIP_SHIFT = 28;
    localparam logic [MUL_B_W-1:0] RECIP_15 = 28'd17895697;
    localparam logic [3:0]         SCALE_DIV = 4'h0F;

    // Polynomial step counter
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_A_LAST  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_B_FIRST = 3'd3;
    localparam logic [STEP_W-1:0] STEP_B_LAST  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RECIP,
        S_DIVFIX,
        S_SCALE,
        S_LOAD,
        S_MUL_LO,
        S_MUL_HI,
        S_PROD,
        S_ACC,
        S_SUM,
        S_ROUND,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_RECIP,
        OP_DIVFIX,
        OP_SCALE,
        OP_LOAD,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_PROD,
        OP_ACC,
        OP_SUM,
        OP_ROUND,
        OP_FINISH
    } t_dp_op;

    typedef enum logic [3:0] {
        COEF_ZERO,
        COEF_C0H,
        COEF_C1,
        COEF_C00,
        COEF_C10,
        COEF_C01,
        COEF_C11,
        COEF_C20,
        COEF_C21,
        COEF_C30
    } t_coef_sel;

    typedef struct packed {
        t_dp_op    op;
        t_coef_sel coef;
        logic      use_temp;
        logic      save_part;
        logic      keep_temp;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic out_free;
    } t_dp_status;

    // Unpacked calibration coefficients, two's complement
    typedef struct packed {
        logic [10:0] c0h;
        logic [11:0] c1;
        logic [19:0] c00;
        logic [19:0] c10;
        logic [15:0] c01;
        logic [15:0] c11;
        logic [15:0] c20;
        logic [15:0] c21;
        logic [15:0] c30;
    } t_coefs;

    // floor(r * 2048 / 15) for remainders 0..14
    function automatic logic [10:0] scale_frac(input logic [3:0] r);
        logic [10:0] f;
        case (r)
            4'd0:    f = 11'd0;
            4'd1:    f = 11'd136;
            4'd2:    f = 11'd273;
            4'd3:    f = 11'd409;
            4'd4:    f = 11'd546;
            4'd5:    f = 11'd682;
            4'd6:    f = 11'd819;
            4'd7:    f = 11'd955;
            4'd8:    f = 11'd1092;
            4'd9:    f = 11'd1228;
            4'd10:   f = 11'd1365;
            4'd11:   f = 11'd1501;
            4'd12:   f = 11'd1638;
            4'd13:   f = 11'd1774;
            4'd14:   f = 11'd1911;
            default: f = 11'd0;
        endcase
        return f;
    endfunction

endpackage

/* rtl/bsc_cal.sv */
module bsc_cal (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsc_pkg::REG_W-1:0]      i_cfg_data,
    output bsc_pkg::t_coefs                o_coefs
);
    import bsc_pkg::*;

    logic [REG_W-1:0] r_cal_first;
    logic [REG_W-1:0] r_cal_middle;
    logic [REG_W-1:0] r_cal_last;
    logic [11:0]      c0;
    logic [11:0]      c0_adj;

    // Calibration register file; unused index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_first  <= '0;
            r_cal_middle <= '0;
            r_cal_last   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST:  r_cal_first  <= i_cfg_data;
                CFG_MIDDLE: r_cal_middle <= i_cfg_data;
                CFG_LAST:   r_cal_last   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // c0 halved, truncating toward zero: add one when negative, then shift
    assign c0     = r_cal_first[47:36];
    assign c0_adj = c0 + {11'd0, c0[11]};

    // Byte unpacking (first byte of each register in its top eight bits)
    always_comb begin
        o_coefs.c0h = c0_adj[11:1];
        o_coefs.c1  = r_cal_first[35:24];
        o_coefs.c00 = r_cal_first[23:4];
        o_coefs.c10 = {r_cal_first[3:0], r_cal_middle[47:32]};
        o_coefs.c01 = r_cal_middle[31:16];
        o_coefs.c11 = r_cal_middle[15:0];
        o_coefs.c20 = r_cal_last[47:32];
        o_coefs.c21 = r_cal_last[31:16];
        o_coefs.c30 = r_cal_last[15:0];
    end

endmodule

/* rtl/bsc_ctrl.sv */
`include "baro_sensor_compensation_assert.svh"

module bsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bsc_pkg::t_dp_status i_status,
    output bsc_pkg::t_dp_cmd    o_cmd
);
    import bsc_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic                is_temp;
    t_coef_sel           acc_coef;

    assign is_temp = (i_status.kind == KIND_TEMP);

    // Coefficient added after each pressure product
    always_comb begin
        case (r_step)
            3'd0:    acc_coef = COEF_C20;
            3'd1:    acc_coef = COEF_C10;
            3'd3:    acc_coef = COEF_C11;
            3'd4:    acc_coef = COEF_C01;
            default: acc_coef = COEF_ZERO;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        o_in_ready      = 1'b0;
        o_cmd.op        = OP_NONE;
        o_cmd.coef      = COEF_ZERO;
        o_cmd.use_temp  = 1'b0;
        o_cmd.save_part = 1'b0;
        o_cmd.keep_temp = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_RECIP;
                end
            end
            S_RECIP: begin
                o_cmd.op = OP_RECIP;
                n_state  = S_DIVFIX;
            end
            S_DIVFIX: begin
                o_cmd.op = OP_DIVFIX;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.op = OP_SCALE;
                n_step   = '0;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                if (is_temp) begin
                    o_cmd.coef = COEF_C1;
                end else if (r_step == STEP_B_FIRST) begin
                    o_cmd.coef      = COEF_C21;
                    o_cmd.save_part = 1'b1;
                end else begin
                    o_cmd.coef = COEF_C30;
                end
                n_state = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.op       = OP_MUL_LO;
                o_cmd.use_temp = !is_temp && (r_step == STEP_B_LAST);
                n_state        = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.op       = OP_MUL_HI;
                o_cmd.use_temp = !is_temp && (r_step == STEP_B_LAST);
                n_state        = S_PROD;
            end
            S_PROD: begin
                o_cmd.op = OP_PROD;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                if (is_temp) begin
                    o_cmd.coef = COEF_C0H;
                    n_state    = S_ROUND;
                end else begin
                    o_cmd.coef = acc_coef;
                    if (r_step == STEP_B_LAST) begin
                        n_state = S_SUM;
                    end else if (r_step == STEP_A_LAST) begin
                        n_step  = r_step + 3'd1;
                        n_state = S_LOAD;
                    end else begin
                        n_step  = r_step + 3'd1;
                        n_state = S_MUL_LO;
                    end
                end
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.op        = OP_ROUND;
                o_cmd.coef      = is_temp ? COEF_ZERO : COEF_C00;
                o_cmd.keep_temp = is_temp;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `BSC_ASSERT_NEXT(a_accept_starts, (r_state == S_IDLE) && i_in_valid, r_state == S_RECIP, "accepted transaction did not start the sequence")
    `BSC_ASSERT_SAME(a_finish_free, o_cmd.op == OP_FINISH, i_status.out_free, "result written while output register busy")
    `BSC_ASSERT_SAME(a_step_bound, r_state == S_MUL_LO, r_step <= STEP_B_LAST, "polynomial step out of range")

endmodule

/* rtl/bsc_dpath.sv */
`include "baro_sensor_compensation_assert.svh"

module bsc_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bsc_pkg::t_dp_cmd            i_cmd,
    output bsc_pkg::t_dp_status         o_status,
    input  bsc_pkg::t_coefs             i_coefs,
    input  logic                        i_req_type,
    input  logic [bsc_pkg::RAW_W-1:0]   i_raw_sample,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_result_kind,
    output logic signed [bsc_pkg::OUT_W-1:0] o_compensated_value,
    output logic                        o_saturated
);
    import bsc_pkg::*;

    localparam logic [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-RND_SHIFT){1'b0}}, 1'b1, {(RND_SHIFT-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Sample and scaling registers
    logic                      r_kind;
    logic                      r_neg;
    logic [RAW_W-1:0]          r_mag;
    logic [Q_W-1:0]            r_quot;
    logic [3:0]                r_rem;
    logic signed [MUL_A_W-1:0] r_s;
    logic signed [MUL_A_W-1:0] r_t;
    // Polynomial registers
    logic signed [MUL_P_W-1:0] r_mul;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   r_part;
    // Output register
    logic                      r_out_valid;
    logic                      r_out_kind;
    logic signed [OUT_W-1:0]   r_out_value;
    logic                      r_out_sat;

    logic [RAW_W-1:0]          raw_mag;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic [Q_W-1:0]            q_est;
    logic [RAW_W-1:0]          q_times15;
    logic [RAW_W-1:0]          rem_full;
    logic [4:0]                rem_est;
    logic                      rem_fix;
    logic [4:0]                rem_sub;
    logic [MUL_A_W-2:0]        s_mag;
    logic signed [COEF_W-1:0]  coef_ext;
    logic signed [ACC_W-1:0]   coef_q30;
    logic signed [PROD_W-1:0]  prod_hi;
    logic [2:0]                acc_top;
    logic                      sat;

    // Magnitude of the sign-extended raw sample
    assign raw_mag = i_raw_sample[RAW_W-1] ? (~i_raw_sample + 24'd1) : i_raw_sample;

    // Shared multiplier operand selection
    always_comb begin
        case (i_cmd.op)
            OP_RECIP: begin
                mul_a = $signed({{(MUL_A_W-RAW_W){1'b0}}, r_mag});
                mul_b = $signed(RECIP_15);
            end
            OP_MUL_LO: begin
                mul_a = i_cmd.use_temp ? r_t : r_s;
                mul_b = $signed({1'b0, r_acc[SPLIT-1:0]});
            end
            default: begin
                mul_a = i_cmd.use_temp ? r_t : r_s;
                mul_b = $signed({r_acc[ACC_W-1], r_acc[ACC_W-1:SPLIT]});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Divide by 15: reciprocal estimate is low by at most one
    assign q_est     = r_mul[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
    assign q_times15 = {q_est, 4'd0} - {4'd0, q_est};
    assign rem_full  = r_mag - q_times15;
    assign rem_est   = rem_full[4:0];
    assign rem_fix   = (rem_est >= {1'b0, SCALE_DIV});
    assign rem_sub   = rem_est - {1'b0, SCALE_DIV};

    // Quotient times 2048 plus the fraction of the remainder
    assign s_mag = {r_quot, scale_frac(r_rem)};

    // Coefficient select, sign-extended and placed at Q30
    always_comb begin
        case (i_cmd.coef)
            COEF_C0H: coef_ext = $signed({{(COEF_W-11){i_coefs.c0h[10]}}, i_coefs.c0h});
            COEF_C1:  coef_ext = $signed({{(COEF_W-12){i_coefs.c1[11]}}, i_coefs.c1});
            COEF_C00: coef_ext = $signed({{(COEF_W-20){i_coefs.c00[19]}}, i_coefs.c00});
            COEF_C10: coef_ext = $signed({{(COEF_W-20){i_coefs.c10[19]}}, i_coefs.c10});
            COEF_C01: coef_ext = $signed({{(COEF_W-16){i_coefs.c01[15]}}, i_coefs.c01});
            COEF_C11: coef_ext = $signed({{(COEF_W-16){i_coefs.c11[15]}}, i_coefs.c11});
            COEF_C20: coef_ext = $signed({{(COEF_W-16){i_coefs.c20[15]}}, i_coefs.c20});
            COEF_C21: coef_ext = $signed({{(COEF_W-16){i_coefs.c21[15]}}, i_coefs.c21});
            COEF_C30: coef_ext = $signed({{(COEF_W-16){i_coefs.c30[15]}}, i_coefs.c30});
            default:  coef_ext = '0;
        endcase
    end

    assign coef_q30 = $signed({coef_ext, {Q_FRAC{1'b0}}});
    assign prod_hi  = $signed({r_mul, {SPLIT{1'b0}}});

    // Output rounding already added; check that the Q10 value fits 32 bits
    assign acc_top = r_acc[ACC_W-1:RND_SHIFT+OUT_W-1];
    assign sat     = !((&acc_top) || (~|acc_top));

    // Control state: kept temperature and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_ROUND && i_cmd.keep_temp) begin
                r_t <= r_s;
            end
            if (i_cmd.op == OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_kind <= i_req_type;
                r_neg  <= i_raw_sample[RAW_W-1];
                r_mag  <= raw_mag;
            end
            OP_RECIP: begin
                r_mul <= mul_p;
            end
            OP_DIVFIX: begin
                r_quot <= rem_fix ? (q_est + 20'd1) : q_est;
                r_rem  <= rem_fix ? rem_sub[3:0] : rem_est[3:0];
            end
            OP_SCALE: begin
                r_s <= r_neg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
            end
            OP_LOAD: begin
                r_acc <= coef_q30;
                if (i_cmd.save_part) begin
                    r_part <= r_acc;
                end
            end
            OP_MUL_LO: begin
                r_mul <= mul_p;
            end
            OP_MUL_HI: begin
                r_mul  <= mul_p;
                r_prod <= $signed({{SPLIT{r_mul[MUL_P_W-1]}}, r_mul});
            end
            OP_PROD: begin
                r_prod <= r_prod + prod_hi;
            end
            OP_ACC: begin
                r_acc <= coef_q30 + r_prod[Q_FRAC+ACC_W-1:Q_FRAC];
            end
            OP_SUM: begin
                r_acc <= r_acc + r_part;
            end
            OP_ROUND: begin
                r_acc <= r_acc + (coef_q30 | $signed(ROUND_HALF));
            end
            OP_FINISH: begin
                r_out_kind  <= r_kind;
                r_out_sat   <= sat;
                r_out_value <= sat ? (r_acc[ACC_W-1] ? OUT_MIN : OUT_MAX)
                                   : r_acc[RND_SHIFT+OUT_W-1:RND_SHIFT];
            end
            default: ;
        endcase
    end

    assign o_status.kind      = r_kind;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_result_kind       = r_out_kind;
    assign o_compensated_value = r_out_value;
    assign o_saturated         = r_out_sat;

    `BSC_ASSERT_NEXT(a_finish_sets_valid, i_cmd.op == OP_FINISH, o_out_valid, "finished result not presented")
    `BSC_ASSERT_SAME(a_rem_reduced, i_cmd.op == OP_SCALE, r_rem != SCALE_DIV, "divide-by-15 remainder not reduced")

endmodule

/* rtl/baro_sensor_compensation.sv */
// Barometric sensor compensation. Calibration bytes are written through the
// register port (index 0..2, six bytes each, first byte in bits 47:40); the
// user must write them only while the block is idle, which the block does not
// enforce. Each transaction on the input channel carries one 24-bit raw
// sample tagged temperature (0) or pressure (1) and yields exactly one
// result: the compensated value as signed Q10 with round-half-up and 32-bit
// saturation, plus a flag when clipping happened. A temperature sample also
// updates the kept scaled temperature used by later pressure samples (zero
// after reset). One sample is processed at a time: a new sample is accepted
// only after the previous result has been written to the output register.
// The pace is set by the single shared 32x28 multiplier; each Q30 product
// takes two partial products, a combine and an accumulate. Pressure needs six
// such products, temperature one, after the raw sample is scaled by a
// reciprocal multiply, a remainder fix and a scale step. The output register
// holds a finished result while the next sample is accepted; the block only
// stalls if a second result is ready before the first was taken.
module baro_sensor_compensation (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_req_type,
    input  logic [bsc_pkg::RAW_W-1:0]        i_raw_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_result_kind,
    output logic signed [bsc_pkg::OUT_W-1:0] o_compensated_value,
    output logic                             o_saturated,
    input  logic                             i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bsc_pkg::REG_W-1:0]        i_cfg_data
);
    import bsc_pkg::*;

    t_coefs     coefs;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Calibration registers and coefficient unpacking
    bsc_cal u_cal (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (coefs)
    );

    // Sequencer
    bsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Scaling, polynomial evaluation and output register
    bsc_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_status            (dp_status),
        .i_coefs             (coefs),
        .i_req_type          (i_req_type),
        .i_raw_sample        (i_raw_sample),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_result_kind       (o_result_kind),
        .o_compensated_value (o_compensated_value),
        .o_saturated         (o_saturated)
    );

endmodule

/* tb/sv/tb_baro_sensor_compensation.sv */
`timescale 1ns / 1ps

module tb_baro_sensor_compensation;
    import bsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 228;
    localparam int REPORT_LIMIT   = 10;

    // Index past the last calibration register, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [127:0] Q30_ONE   = 128'sd1 <<< 30;
    localparam logic signed [127:0] ROUND_BIAS = 128'sd1 <<< 19;
    localparam logic signed [127:0] OUT_MAX   = 128'sd2147483647;
    localparam logic signed [127:0] OUT_MIN   = -128'sd2147483648;

    typedef struct packed {
        logic             kind;
        logic [RAW_W-1:0] raw;
    } t_sample;

    typedef struct packed {
        logic                    kind;
        logic signed [OUT_W-1:0] value;
        logic                    sat;
    } t_comp_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    req_type = 1'b0;
    logic [RAW_W-1:0]        raw_sample = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    result_kind;
    logic signed [OUT_W-1:0] compensated_value;
    logic                    saturated;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [REG_W-1:0]        cfg_data = '0;

    t_sample      pending_samples[$];
    t_comp_result predicted_outputs[$];
    logic         in_taken = 1'b0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           mismatch_count = 0;
    int           quiet_cycles = 0;

    // Calibration shadow and kept scaled temperature
    logic [REG_W-1:0]  cal_shadow [3];
    logic signed [31:0] kept_tsc;

    baro_sensor_compensation dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_req_type          (req_type),
        .i_raw_sample        (raw_sample),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_result_kind       (result_kind),
        .o_compensated_value (compensated_value),
        .o_saturated         (saturated),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // raw * 2^30 / 7864320, truncated toward zero
    function automatic logic signed [127:0] scale_raw(input logic [RAW_W-1:0] raw);
        logic signed [127:0] r;
        r = 128'($signed(raw));
        return (r * 2048) / 15;
    endfunction

    // Exact product of two Q30 values, floored back to Q30
    function automatic logic signed [127:0] mul_floor_q30(input logic signed [127:0] a,
                                                          input logic signed [127:0] b);
        logic signed [127:0] p;
        p = a * b;
        return p >>> 30;
    endfunction

    function automatic t_comp_result compensate_sample(input logic kind,
                                                       input logic [RAW_W-1:0] raw,
                                                       input logic [143:0] cal,
                                                       input logic signed [31:0] tsc);
        logic signed [127:0] s, t, a, b, sum, rnd;
        logic signed [127:0] k_c0h, k_c1, k_c00, k_c10, k_c01, k_c11, k_c20, k_c21, k_c30;
        t_comp_result res;
        s     = scale_raw(raw);
        t     = 128'(tsc);
        k_c0h = 128'($signed(cal[143:132]));
        k_c0h = k_c0h / 2;
        k_c1  = 128'($signed(cal[131:120]));
        k_c00 = 128'($signed(cal[119:100]));
        k_c10 = 128'($signed(cal[99:80]));
        k_c01 = 128'($signed(cal[79:64]));
        k_c11 = 128'($signed(cal[63:48]));
        k_c20 = 128'($signed(cal[47:32]));
        k_c21 = 128'($signed(cal[31:16]));
        k_c30 = 128'($signed(cal[15:0]));
        if (kind == KIND_TEMP) begin
            sum = k_c0h * Q30_ONE + k_c1 * s;
        end else begin
            // Horner chain in the pressure, temperature terms on the side
            a   = k_c20 * Q30_ONE + s * k_c30;
            a   = k_c10 * Q30_ONE + mul_floor_q30(s, a);
            a   = mul_floor_q30(s, a);
            b   = k_c11 * Q30_ONE + s * k_c21;
            b   = k_c01 * Q30_ONE + mul_floor_q30(s, b);
            b   = mul_floor_q30(t, b);
            sum = k_c00 * Q30_ONE + a + b;
        end
        // Q30 to Q10, half rounds up, then clip to 32 bits
        rnd = (sum + ROUND_BIAS) >>> 20;
        res.kind = kind;
        res.sat  = 1'b0;
        if (rnd > OUT_MAX) begin
            rnd     = OUT_MAX;
            res.sat = 1'b1;
        end else if (rnd < OUT_MIN) begin
            rnd     = OUT_MIN;
            res.sat = 1'b1;
        end
        res.value = rnd[31:0];
        return res;
    endfunction

    // Driver: one sample transaction at a time, plus receiver backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            if (in_valid && !in_taken) begin
                // hold until accepted
            end else if (pending_samples.size() != 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                in_valid   <= 1'b1;
                req_type   <= pending_samples[0].kind;
                raw_sample <= pending_samples[0].raw;
                void'(pending_samples.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: track config, predict on input transactions, check outputs
    always @(posedge i_clk) begin : monitor
        t_comp_result exp_res;
        logic         in_fire;
        logic         out_fire;
        if (!i_rst_n) begin
            cal_shadow[0] = '0;
            cal_shadow[1] = '0;
            cal_shadow[2] = '0;
            kept_tsc      = '0;
            quiet_cycles  = 0;
            in_taken     <= 1'b0;
        end else begin
            in_fire  = in_valid && in_ready;
            out_fire = out_valid && out_ready;
            if (cfg_we && cfg_index <= CFG_LAST)
                cal_shadow[cfg_index] = cfg_data;
            if (in_fire) begin
                predicted_outputs.push_back(compensate_sample(req_type, raw_sample,
                    {cal_shadow[0], cal_shadow[1], cal_shadow[2]}, kept_tsc));
                if (req_type == KIND_TEMP)
                    kept_tsc = 32'(scale_raw(raw_sample));
            end
            if (out_fire) begin
                if (predicted_outputs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: kind=%0b value=%0d sat=%0b",
                                 result_kind, compensated_value, saturated);
                end else begin
                    exp_res = predicted_outputs.pop_front();
                    if (exp_res.kind !== result_kind || exp_res.value !== compensated_value ||
                        exp_res.sat !== saturated) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("mismatch: exp kind/value/sat=%0b/%0d/%0b, got %0b/%0d/%0b",
                                     exp_res.kind, exp_res.value, exp_res.sat,
                                     result_kind, compensated_value, saturated);
                    end
                end
            end
            // Watchdog on cycles without any transaction
            if (in_fire || out_fire)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
            in_taken <= in_fire;
        end
    end

    task automatic cal_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_calibration(input logic [143:0] cal);
        cal_write(CFG_FIRST,  cal[143:96]);
        cal_write(CFG_MIDDLE, cal[95:48]);
        cal_write(CFG_LAST,   cal[47:0]);
    endtask

    task automatic queue_sample(input logic kind, input logic [RAW_W-1:0] raw);
        t_sample smp;
        smp.kind = kind;
        smp.raw  = raw;
        pending_samples.push_back(smp);
    endtask

    // Wait until all samples are sent and every result is back, then settle
    task automatic wait_for_drain();
        while (pending_samples.size() != 0 || in_valid || predicted_outputs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [143:0] random_calibration();
        logic [143:0] cal;
        cal = '0;
        for (int i = 0; i < 5; i++)
            cal = (cal << 32) | 144'($urandom());
        return cal;
    endfunction

    // Sequencer
    initial begin : stimulus
        logic [143:0]     cal;
        logic [RAW_W-1:0] raw;
        logic             kind;
        int               pick;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Mixed-sign calibration; the write to the unused index must be dropped
        load_calibration({12'hA53, 12'h3C7, 20'h8F3A1, 20'h1B2C4, 16'hE5D2,
                          16'h0F3B, 16'h9A7E, 16'h4C21, 16'hF0B3});
        cal_write(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);

        // Pressure before any temperature uses the reset scaled temperature
        queue_sample(KIND_PRES, 24'h7FFFFF);
        queue_sample(KIND_TEMP, 24'h000000);
        queue_sample(KIND_TEMP, 24'h7FFFFF);
        queue_sample(KIND_PRES, 24'h800000);
        // Back-to-back pressure keeps the same scaled temperature
        queue_sample(KIND_PRES, 24'hFFFFFF);
        queue_sample(KIND_TEMP, 24'h800000);
        queue_sample(KIND_PRES, 24'h000000);
        queue_sample(KIND_TEMP, 24'hFFFFFF);
        queue_sample(KIND_PRES, 24'h000001);
        queue_sample(KIND_TEMP, 24'h000001);
        queue_sample(KIND_PRES, 24'h7FFFFF);
        wait_for_drain();

        // All ones: every coefficient is -1, c0 halves to zero
        load_calibration({144{1'b1}});
        queue_sample(KIND_TEMP, 24'h7FFFFF);
        queue_sample(KIND_PRES, 24'h800000);
        queue_sample(KIND_TEMP, 24'h800000);
        queue_sample(KIND_PRES, 24'h7FFFFF);
        wait_for_drain();

        // Largest positive coefficients
        load_calibration({12'h7FF, 12'h7FF, 20'h7FFFF, 20'h7FFFF, {5{16'h7FFF}}});
        queue_sample(KIND_TEMP, 24'h7FFFFF);
        queue_sample(KIND_PRES, 24'h7FFFFF);
        queue_sample(KIND_TEMP, 24'h800000);
        queue_sample(KIND_PRES, 24'h800000);
        wait_for_drain();

        // Most negative coefficients
        load_calibration({12'h800, 12'h800, 20'h80000, 20'h80000, {5{16'h8000}}});
        queue_sample(KIND_TEMP, 24'h800000);
        queue_sample(KIND_PRES, 24'h800000);
        queue_sample(KIND_TEMP, 24'h7FFFFF);
        queue_sample(KIND_PRES, 24'h7FFFFF);
        wait_for_drain();

        // Random phases under each idling pattern
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            if (phase == 3)
                cal = {12'h7FF, 12'h7FF, 20'h7FFFF, 20'h7FFFF, {5{16'h7FFF}}};
            else if (phase == 6)
                cal = {12'h800, 12'h800, 20'h80000, 20'h80000, {5{16'h8000}}};
            else
                cal = random_calibration();
            load_calibration(cal);
            for (int i = 0; i < PHASE_SAMPLES; i++) begin
                kind = ($urandom_range(99) < 40) ? KIND_TEMP : KIND_PRES;
                pick = int'($urandom_range(9));
                case (pick)
                    0: raw = 24'h7FFFFF;
                    1: raw = 24'h800000;
                    2: raw = ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'h000000;
                    default: raw = 24'($urandom());
                endcase
                queue_sample(kind, raw);
            end
            wait_for_drain();
        end

        if (mismatch_count == 0 && predicted_outputs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
